// ----- hw/rtl/qnl_pkg.sv -----
// ----------------------------------------------------------------------------
// qnl_pkg: shared types and constants for the quaternion nlerp unit
// fixed point formats, pipeline depths and lane vector types
// ----------------------------------------------------------------------------
package qnl_pkg;

    // unit length in q2.14 and blend one in q1.16
    localparam int unsigned Q_ONE = 16384;
    localparam logic [16:0] W_ONE = 17'd65536;

    // normalizer datapath widths
    localparam int unsigned LANE_W = 32;                 // signed lane input
    localparam int unsigned MAG_W  = 31;                 // lane magnitude
    localparam int unsigned SQ_W   = 2 * MAG_W;          // lane square
    localparam int unsigned SUM_W  = 64;                 // sum of squares
    localparam int unsigned ROOT_W = SUM_W / 2;          // root bits, one per stage
    localparam int unsigned REM_W  = ROOT_W + 3;         // root remainder
    localparam int unsigned QUO_W  = 15;                 // quotient bits, one per stage
    localparam int unsigned FRAC_SH = 14;                // numerator pre-shift
    localparam int unsigned NUM_W  = MAG_W + FRAC_SH + 1;

    // squares, sum, root stages, numerator, divide stages, final clamp
    localparam int unsigned NORM_LAT = 2 + ROOT_W + 1 + QUO_W + 1;

    typedef logic [3:0][LANE_W-1:0] vec32_t;
    typedef logic [3:0][15:0]       quat_t;

endpackage

// ----- hw/rtl/qnl_norm4.sv -----
// ----------------------------------------------------------------------------
// qnl_norm4: pipelined four-lane vector normalizer
// out_i = round(v_i * 2^14 / floor(sqrt(sum v^2))), clamped to +-1.0 in q2.14
// ----------------------------------------------------------------------------
module qnl_norm4 (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  qnl_pkg::vec32_t in_vec,
    output logic           out_valid,
    output qnl_pkg::quat_t  out_vec
);

    typedef struct packed {
        logic                              zero;
        logic [3:0]                        neg;
        logic [3:0][qnl_pkg::MAG_W-1:0]    mag;
    } side_t;

    // squares stage
    logic [3:0][qnl_pkg::LANE_W-1:0] abs_c;
    logic [3:0][qnl_pkg::SQ_W-1:0]   sq_c;
    side_t                           side1_c;
    logic                            v1_reg;
    side_t                           side1_reg;
    logic [3:0][qnl_pkg::SQ_W-1:0]   sq1_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            abs_c[i] = in_vec[i][qnl_pkg::LANE_W-1] ? (qnl_pkg::LANE_W'(0) - in_vec[i])
                                                     : in_vec[i];
            sq_c[i]  = abs_c[i][qnl_pkg::MAG_W-1:0] * abs_c[i][qnl_pkg::MAG_W-1:0];
            side1_c.neg[i] = in_vec[i][qnl_pkg::LANE_W-1];
            side1_c.mag[i] = abs_c[i][qnl_pkg::MAG_W-1:0];
        end
        side1_c.zero = (in_vec == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_c;
            sq1_reg   <= sq_c;
        end
    end

    // root stages, index 0 holds the sum of squares
    logic                         rv_reg    [0:qnl_pkg::ROOT_W];
    side_t                        rside_reg [0:qnl_pkg::ROOT_W];
    logic [qnl_pkg::SUM_W-1:0]    s_reg     [0:qnl_pkg::ROOT_W];
    logic [qnl_pkg::REM_W-1:0]    rem_reg   [0:qnl_pkg::ROOT_W];
    logic [qnl_pkg::ROOT_W-1:0]   root_reg  [0:qnl_pkg::ROOT_W];
    logic [qnl_pkg::SUM_W-1:0]    sum_c;

    assign sum_c = (qnl_pkg::SUM_W'(sq1_reg[0]) + qnl_pkg::SUM_W'(sq1_reg[1]))
                 + (qnl_pkg::SUM_W'(sq1_reg[2]) + qnl_pkg::SUM_W'(sq1_reg[3]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg[0] <= 1'b0;
        end else if (en) begin
            rv_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rside_reg[0] <= side1_reg;
            s_reg[0]     <= sum_c;
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < qnl_pkg::ROOT_W; k++) begin : g_root
        logic [qnl_pkg::REM_W-1:0] rem_sh;
        logic [qnl_pkg::REM_W-1:0] trial;
        logic                      ge;

        always_comb begin
            rem_sh = {rem_reg[k][qnl_pkg::REM_W-3:0],
                      s_reg[k][2*(qnl_pkg::ROOT_W-1-k)+1 -: 2]};
            trial  = {1'b0, root_reg[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[k+1] <= 1'b0;
            end else if (en) begin
                rv_reg[k+1] <= rv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rside_reg[k+1] <= rside_reg[k];
                s_reg[k+1]     <= s_reg[k];
                rem_reg[k+1]   <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k+1]  <= {root_reg[k][qnl_pkg::ROOT_W-2:0], ge};
            end
        end
    end

    // divide stages, index 0 holds the rounded numerators
    logic                                 dv_reg   [0:qnl_pkg::QUO_W];
    logic                                 dzero_reg[0:qnl_pkg::QUO_W];
    logic [3:0]                           dneg_reg [0:qnl_pkg::QUO_W];
    logic [qnl_pkg::ROOT_W-1:0]           dden_reg [0:qnl_pkg::QUO_W];
    logic [3:0][qnl_pkg::NUM_W-1:0]       dr_reg   [0:qnl_pkg::QUO_W];
    logic [3:0][qnl_pkg::QUO_W-1:0]       dq_reg   [0:qnl_pkg::QUO_W];
    logic [3:0][qnl_pkg::NUM_W-1:0]       num_c;
    logic [qnl_pkg::ROOT_W-1:0]           len_c;
    side_t                                rlast;

    assign len_c = root_reg[qnl_pkg::ROOT_W];
    assign rlast = rside_reg[qnl_pkg::ROOT_W];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            // add half the divisor so the truncating divide rounds half away from zero
            num_c[i] = qnl_pkg::NUM_W'({rlast.mag[i], {qnl_pkg::FRAC_SH{1'b0}}})
                     + qnl_pkg::NUM_W'(len_c >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= rv_reg[qnl_pkg::ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dzero_reg[0] <= rlast.zero;
            dneg_reg[0]  <= rlast.neg;
            dden_reg[0]  <= len_c;
            dr_reg[0]    <= num_c;
            dq_reg[0]    <= '0;
        end
    end

    for (genvar k = 0; k < qnl_pkg::QUO_W; k++) begin : g_div
        logic [qnl_pkg::NUM_W-1:0]       dsh;
        logic [3:0]                      ge;
        logic [3:0][qnl_pkg::NUM_W-1:0]  rn;
        logic [3:0][qnl_pkg::QUO_W-1:0]  qn;

        always_comb begin
            dsh = qnl_pkg::NUM_W'(dden_reg[k]) << (qnl_pkg::QUO_W - 1 - k);
            for (int i = 0; i < 4; i++) begin
                ge[i] = (dr_reg[k][i] >= dsh);
                rn[i] = ge[i] ? (dr_reg[k][i] - dsh) : dr_reg[k][i];
                qn[i] = {dq_reg[k][i][qnl_pkg::QUO_W-2:0], ge[i]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dzero_reg[k+1] <= dzero_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dden_reg[k+1]  <= dden_reg[k];
                dr_reg[k+1]    <= rn;
                dq_reg[k+1]    <= qn;
            end
        end
    end

    // clamp, sign and zero-length override
    qnl_pkg::quat_t                  res_c;
    logic [qnl_pkg::QUO_W-1:0]       qc;
    logic                            out_valid_reg;
    qnl_pkg::quat_t                  out_vec_reg;

    always_comb begin
        qc = '0;
        for (int i = 0; i < 4; i++) begin
            qc = (dq_reg[qnl_pkg::QUO_W][i] > qnl_pkg::QUO_W'(qnl_pkg::Q_ONE))
               ? qnl_pkg::QUO_W'(qnl_pkg::Q_ONE) : dq_reg[qnl_pkg::QUO_W][i];
            if (dzero_reg[qnl_pkg::QUO_W]) begin
                res_c[i] = '0;
            end else if (dneg_reg[qnl_pkg::QUO_W][i]) begin
                res_c[i] = 16'd0 - {1'b0, qc};
            end else begin
                res_c[i] = {1'b0, qc};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_reg[qnl_pkg::QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_vec_reg <= res_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;

endmodule

// ----- hw/rtl/quaternion_nlerp_unit.sv -----
// throughput: one item per cycle while m_tready stays high
// the rate is set by the fully pipelined root and divide units, one bit per stage
// s_tready is registered; it drops only once the output skid stage holds a result
// reset (aresetn low, synchronous) clears all valid bits; data registers keep old values
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit: normalized linear blend of two quaternions
// normalizes both inputs, flips the second onto the shortest arc, blends by
// weight and normalizes the blend; q2.14 components, q1.16 weight
// ----------------------------------------------------------------------------
module quaternion_nlerp_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, first_w, second_x, second_y, second_z,
    // second_w (16 bits each), weight (17 bits), zero fill
    input  logic [151:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_w (16 bits each)
    output logic [63:0]  m_tdata
);

    // global pipeline advance: every stage moves when the skid stage is empty
    logic en;
    logic skid_valid_reg;
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // input stage: unpack fields, saturate weight to one
    // ------------------------------------------------------------------
    logic           in_valid_reg;
    qnl_pkg::quat_t qa_reg;
    qnl_pkg::quat_t qb_reg;
    logic [16:0]    t_reg;
    qnl_pkg::quat_t qa_c;
    qnl_pkg::quat_t qb_c;
    logic [16:0]    t_in;
    logic [16:0]    t_c;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qa_c[i] = s_tdata[16*i +: 16];
            qb_c[i] = s_tdata[64 + 16*i +: 16];
        end
        t_in = s_tdata[144:128];
        // anything above one saturates to one
        t_c  = (t_in > qnl_pkg::W_ONE) ? qnl_pkg::W_ONE : t_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg <= qa_c;
            qb_reg <= qb_c;
            t_reg  <= t_c;
        end
    end

    // ------------------------------------------------------------------
    // unit scaling of both inputs; q * 2^8 makes the root carry the 2^8
    // length scale and the numerator the full 2^22 pre-shift
    // ------------------------------------------------------------------
    qnl_pkg::vec32_t va_c;
    qnl_pkg::vec32_t vb_c;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            va_c[i] = {{8{qa_reg[i][15]}}, qa_reg[i], 8'd0};
            vb_c[i] = {{8{qb_reg[i][15]}}, qb_reg[i], 8'd0};
        end
    end

    logic           na_valid;
    logic           nb_valid;
    qnl_pkg::quat_t ua;
    qnl_pkg::quat_t ub;

    qnl_norm4 u_norm_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid_reg),
        .in_vec   (va_c),
        .out_valid(na_valid),
        .out_vec  (ua)
    );

    // both normalizers run in lockstep; the dot stage takes the AND of both valids
    qnl_norm4 u_norm_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid_reg),
        .in_vec   (vb_c),
        .out_valid(nb_valid),
        .out_vec  (ub)
    );

    // weight travels beside the normalizers
    logic [16:0] t_dly_reg [0:qnl_pkg::NORM_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            t_dly_reg[0] <= t_reg;
            for (int k = 1; k < qnl_pkg::NORM_LAT; k++) begin
                t_dly_reg[k] <= t_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // dot product: products, then sum and sign
    // ------------------------------------------------------------------
    logic                  d1_valid_reg;
    qnl_pkg::quat_t        d1_ua_reg;
    qnl_pkg::quat_t        d1_ub_reg;
    logic [16:0]           d1_t_reg;
    logic [3:0][31:0]      d1_prod_reg;
    logic [3:0][31:0]      prod_c;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod_c[i] = $signed(ua[i]) * $signed(ub[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg <= 1'b0;
        end else if (en) begin
            d1_valid_reg <= na_valid & nb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_ua_reg   <= ua;
            d1_ub_reg   <= ub;
            d1_t_reg    <= t_dly_reg[qnl_pkg::NORM_LAT-1];
            d1_prod_reg <= prod_c;
        end
    end

    logic           d2_valid_reg;
    qnl_pkg::quat_t d2_ua_reg;
    qnl_pkg::quat_t d2_ub_reg;
    logic [16:0]    d2_t_reg;
    logic           d2_flip_reg;
    logic [31:0]    dot_c;

    assign dot_c = (d1_prod_reg[0] + d1_prod_reg[1]) + (d1_prod_reg[2] + d1_prod_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d2_valid_reg <= 1'b0;
        end else if (en) begin
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_ua_reg   <= d1_ua_reg;
            d2_ub_reg   <= d1_ub_reg;
            d2_t_reg    <= d1_t_reg;
            // negative dot: take the shortest arc; exactly zero keeps the sign
            d2_flip_reg <= dot_c[31];
        end
    end

    // ------------------------------------------------------------------
    // blend: a*(1-t) and b*t products, then the signed sum in q.30
    // ------------------------------------------------------------------
    logic             m1_valid_reg;
    logic             m1_flip_reg;
    logic [3:0][33:0] m1_pa_reg;
    logic [3:0][33:0] m1_pb_reg;
    logic [3:0][33:0] pa_c;
    logic [3:0][33:0] pb_c;
    logic [16:0]      wa_c;

    always_comb begin
        wa_c = qnl_pkg::W_ONE - d2_t_reg;
        for (int i = 0; i < 4; i++) begin
            pa_c[i] = $signed(d2_ua_reg[i]) * $signed({1'b0, wa_c});
            pb_c[i] = $signed(d2_ub_reg[i]) * $signed({1'b0, d2_t_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= d2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_flip_reg <= d2_flip_reg;
            m1_pa_reg   <= pa_c;
            m1_pb_reg   <= pb_c;
        end
    end

    logic            m2_valid_reg;
    qnl_pkg::vec32_t m2_mix_reg;
    qnl_pkg::vec32_t mix_c;
    logic [33:0]     msum;

    always_comb begin
        msum = '0;
        for (int i = 0; i < 4; i++) begin
            msum     = m1_flip_reg ? (m1_pa_reg[i] - m1_pb_reg[i])
                                   : (m1_pa_reg[i] + m1_pb_reg[i]);
            // a convex blend of unit components stays within +-2^30
            mix_c[i] = msum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (en) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m2_mix_reg <= mix_c;
        end
    end

    // ------------------------------------------------------------------
    // final normalization; a zero-length blend comes out all zero
    // ------------------------------------------------------------------
    logic           nm_valid;
    qnl_pkg::quat_t nm_vec;

    qnl_norm4 u_norm_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (m2_valid_reg),
        .in_vec   (m2_mix_reg),
        .out_valid(nm_valid),
        .out_vec  (nm_vec)
    );

    // ------------------------------------------------------------------
    // output register plus skid stage; a result leaves the pipeline on
    // every advance that carries a valid item
    // ------------------------------------------------------------------
    logic           push;
    logic           out_valid_reg;
    logic           out_valid_next;
    qnl_pkg::quat_t out_data_reg;
    qnl_pkg::quat_t out_data_next;
    logic           skid_valid_next;
    qnl_pkg::quat_t skid_data_reg;
    qnl_pkg::quat_t skid_data_next;

    assign push = en & nm_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // pipeline is frozen while the skid stage is full
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = nm_vec;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = nm_vec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/qnl_checker.sv -----
// ----------------------------------------------------------------------------
// qnl_checker: port-level checks for the quaternion nlerp unit
// watches the stream ports only; attached to the top level by bind
// ----------------------------------------------------------------------------
module qnl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [151:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata
);

    // stalled result stays presented
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // every component of a unit result lies within +-1.0
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[15:0])  >= -16384) && ($signed(m_tdata[15:0])  <= 16384) &&
            ($signed(m_tdata[31:16]) >= -16384) && ($signed(m_tdata[31:16]) <= 16384) &&
            ($signed(m_tdata[47:32]) >= -16384) && ($signed(m_tdata[47:32]) <= 16384) &&
            ($signed(m_tdata[63:48]) >= -16384) && ($signed(m_tdata[63:48]) <= 16384))
        else $error("result component out of range");

    // one transfer on the result side frees the input side
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("input side stuck after result transfer");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

bind quaternion_nlerp_unit qnl_checker u_qnl_checker (.*);
